// ===== hw/rtl/text_console_pixel_renderer_assert.svh =====
// Assertion macros for the text console renderer RTL.
// Expects the including module to have aclk and aresetn in scope.
`ifndef TEXT_CONSOLE_PIXEL_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_PIXEL_RENDERER_ASSERT_SVH

// Check a condition at every rising clock edge out of reset
`define TCPR_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("tcpr: invariant violated");

// Check that a condition leads to another in the next cycle
`define TCPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcpr: sequencing violated");

`endif

// ===== hw/rtl/tcpr_pkg.sv =====
// Package for the text console pixel renderer: types, codes, cell geometry, font ROM.
// No dependencies.
package tcpr_pkg;

    typedef logic [15:0] color_t;
    typedef logic [7:0]  code_t;
    typedef logic [55:0] glyph_t;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'd1;

    localparam color_t FG_RESET = 16'hFFFF;
    localparam color_t BG_RESET = 16'h001F;

    // Character codes
    localparam code_t SPACE_CODE   = 8'h20;
    localparam code_t NEWLINE_CODE = 8'h0A;
    localparam code_t LAST_PRINT   = 8'h7F;
    localparam logic [6:0] SPACE7  = 7'h20;

    // Fixed state widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;
    localparam int RX_W   = 9;
    localparam int RY_W   = 8;
    localparam int CX_W   = 7;
    localparam int IX_W   = 3;
    localparam int CY_W   = 5;
    localparam int JY_W   = 4;
    localparam int BIT_W  = 6;
    localparam int CHAR_W = 7;

    // Cell geometry
    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 10;
    localparam int CELL_W  = GLYPH_W + 1;

    // Default dimensions
    localparam int TEXT_ROWS_DEF     = 24;
    localparam int TEXT_COLS_DEF     = 56;
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // Font ROM: glyph for code 0x20 + idx, bits packed LSB first in raster order
    function automatic glyph_t tcpr_glyph(input logic [6:0] idx);
        glyph_t g;
        case (idx)
            7'd0:  g = 56'h00000000000000;
            7'd1:  g = 56'h00002008421080;
            7'd2:  g = 56'h0000000000294A;
            7'd3:  g = 56'h000057D4AFA800;
            7'd4:  g = 56'h000023E8E2F880;
            7'd5:  g = 56'h0000CE44444E60;
            7'd6:  g = 56'h0000B26A64A4C0;
            7'd7:  g = 56'h00000000001084;
            7'd8:  g = 56'h00082084210888;
            7'd9:  g = 56'h00022210842082;
            7'd10: g = 56'h0000012AEA9000;
            7'd11: g = 56'h00000109F21000;
            7'd12: g = 56'h00022000000000;
            7'd13: g = 56'h00000001F00000;
            7'd14: g = 56'h00002000000000;
            7'd15: g = 56'h00011088442210;
            7'd16: g = 56'h0000746358C5C0;
            7'd17: g = 56'h00007108421880;
            7'd18: g = 56'h0000F844C845C0;
            7'd19: g = 56'h00007460C845C0;
            7'd20: g = 56'h0000423E953100;
            7'd21: g = 56'h00007460F087E0;
            7'd22: g = 56'h00007462F08980;
            7'd23: g = 56'h000011088443E0;
            7'd24: g = 56'h00007462E8C5C0;
            7'd25: g = 56'h00003221E8C5C0;
            7'd26: g = 56'h00000100020000;
            7'd27: g = 56'h00001100020000;
            7'd28: g = 56'h00000418364000;
            7'd29: g = 56'h0000003E0F8000;
            7'd30: g = 56'h0000004D830400;
            7'd31: g = 56'h000020088845C0;
            7'd32: g = 56'h0000F07B5AC5C0;
            7'd33: g = 56'h00008C5CA51080;
            7'd34: g = 56'h00007C62F8C5E0;
            7'd35: g = 56'h0000744210C5C0;
            7'd36: g = 56'h00003A6318A4E0;
            7'd37: g = 56'h0000F842F087E0;
            7'd38: g = 56'h00000842F087E0;
            7'd39: g = 56'h0000F46390C5C0;
            7'd40: g = 56'h00008C63F8C620;
            7'd41: g = 56'h000071084211C0;
            7'd42: g = 56'h00007C21084380;
            7'd43: g = 56'h00008A4A32A620;
            7'd44: g = 56'h0000F842108420;
            7'd45: g = 56'h00008D6BBDC620;
            7'd46: g = 56'h0000CE6B5ACE60;
            7'd47: g = 56'h0000746318C5C0;
            7'd48: g = 56'h00000842F8C5E0;
            7'd49: g = 56'h0000F66318C5C0;
            7'd50: g = 56'h00008C62F8C5E0;
            7'd51: g = 56'h00007460E0C5C0;
            7'd52: g = 56'h000021084213E0;
            7'd53: g = 56'h0000746318C620;
            7'd54: g = 56'h00002114A8C620;
            7'd55: g = 56'h000052955AD620;
            7'd56: g = 56'h00008C54454620;
            7'd57: g = 56'h00002108E8C620;
            7'd58: g = 56'h0000F8444443E0;
            7'd59: g = 56'h000E108421084E;
            7'd60: g = 56'h00104208410821;
            7'd61: g = 56'h000E421084210E;
            7'd62: g = 56'h0000000008A880;
            7'd63: g = 56'h001F0000000000;
            7'd64: g = 56'h00000000002080;
            7'd65: g = 56'h0000F47D070000;
            7'd66: g = 56'h00007C63178421;
            7'd67: g = 56'h0000F0421F0000;
            7'd68: g = 56'h0000F4631F4210;
            7'd69: g = 56'h0000F07F170000;
            7'd70: g = 56'h0000108427885C;
            7'd71: g = 56'h01D0F463170000;
            7'd72: g = 56'h00008C63178421;
            7'd73: g = 56'h00002108430080;
            7'd74: g = 56'h00E84210860100;
            7'd75: g = 56'h0000928CA90842;
            7'd76: g = 56'h00002108421086;
            7'd77: g = 56'h0000AD6B558000;
            7'd78: g = 56'h00008C63178000;
            7'd79: g = 56'h00007463170000;
            7'd80: g = 56'h00217C63178000;
            7'd81: g = 56'h0210F4631F0000;
            7'd82: g = 56'h00000843368000;
            7'd83: g = 56'h00007C1C1F0000;
            7'd84: g = 56'h0000E084270840;
            7'd85: g = 56'h0000F463188000;
            7'd86: g = 56'h00002295188000;
            7'd87: g = 56'h000052AB588000;
            7'd88: g = 56'h00008A88A88000;
            7'd89: g = 56'h01D0F463188000;
            7'd90: g = 56'h0000F8888F8000;
            7'd91: g = 56'h00082108221088;
            7'd92: g = 56'h00042108421084;
            7'd93: g = 56'h00022108821082;
            7'd94: g = 56'h0000001B600000;
            default: g = 56'h00000000000000;
        endcase
        return g;
    endfunction

endpackage

// ===== hw/rtl/text_console_pixel_renderer.sv =====
// Pixel path: one item per cycle while the result register drains; stalls when it is held.
// Clear and character transactions complete in the cycle they are accepted.
// The pixel path has two stages: store RAM read, then font ROM lookup and color select.
// Reset (synchronous, active low) homes cursor and raster and restores the colors.
// Store contents are not swept: per-row fill lengths reset to zero mark every cell blank.
module text_console_pixel_renderer #(
    parameter int TEXT_ROWS     = tcpr_pkg::TEXT_ROWS_DEF,
    parameter int TEXT_COLS     = tcpr_pkg::TEXT_COLS_DEF,
    parameter int SCREEN_WIDTH  = tcpr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcpr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  tcpr_pkg::code_t                s_char_code,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tcpr_pkg::color_t               m_pixel_color,
    output logic                           m_last_of_frame,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  tcpr_pkg::color_t               cfg_data
);
    import tcpr_pkg::*;

`include "text_console_pixel_renderer_assert.svh"

    localparam int STORE_DEPTH = TEXT_ROWS * TEXT_COLS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ROW_IDX_W   = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

    // Configuration registers
    color_t fg_color_reg, bg_color_reg;

    // Cursor and per-row fill lengths
    logic [ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [COL_W-1:0] row_len_reg [TEXT_ROWS];

    // Raster position, kept with its cell coordinates
    logic [RX_W-1:0] raster_x_reg, raster_x_next;
    logic [RY_W-1:0] raster_y_reg, raster_y_next;
    logic [CX_W-1:0] raster_cx_reg, raster_cx_next;
    logic [IX_W-1:0] raster_ix_reg, raster_ix_next;
    logic [CY_W-1:0] raster_cy_reg, raster_cy_next;
    logic [JY_W-1:0] raster_jy_reg, raster_jy_next;

    // Lookup stage
    logic             s1_valid_reg;
    logic             s1_show_reg;
    logic [BIT_W-1:0] s1_bit_reg;
    logic             s1_last_reg;

    // Result register
    logic   m_valid_reg;
    color_t m_pixel_color_reg;
    logic   m_last_reg;

    logic s_fire, is_clear, is_char, is_pixel;
    logic out_free, out_load;
    logic cursor_ok, char_print, char_newline, store_wr;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [ROW_IDX_W-1:0] cur_row_idx, rd_row_idx;
    logic                 row_ok, cell_ok, show;
    logic [COL_W-1:0]     rd_row_len;
    logic [BIT_W-1:0]     bit_idx;
    logic                 last_pix, x_wrap, y_wrap;
    logic [CHAR_W-1:0]    rd_code;
    glyph_t               glyph;
    logic                 glyph_on;

    // Decode the input transaction
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;
    assign is_clear = s_fire && (s_kind == KIND_CLEAR);
    assign is_char  = s_fire && (s_kind == KIND_CHAR);
    assign is_pixel = s_fire && (s_kind == KIND_PIXEL);

    // Cursor update for clear and character transactions
    always_comb begin
        cursor_ok    = (32'(cursor_row_reg) < TEXT_ROWS) && (32'(cursor_col_reg) < TEXT_COLS);
        char_newline = (s_char_code == NEWLINE_CODE);
        char_print   = (s_char_code >= SPACE_CODE) && (s_char_code <= LAST_PRINT);
        store_wr     = is_char && cursor_ok && char_print;
        cur_row_idx  = cursor_ok ? cursor_row_reg[ROW_IDX_W-1:0] : '0;
        wr_addr      = cursor_ok ?
                       ADDR_W'(32'(cursor_row_reg) * TEXT_COLS + 32'(cursor_col_reg)) : '0;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        if (is_clear) begin
            cursor_row_next = '0;
            cursor_col_next = '0;
        end else if (is_char && cursor_ok) begin
            if (char_newline) begin
                cursor_row_next = cursor_row_reg + ROW_W'(1);
                cursor_col_next = '0;
            end else if (char_print) begin
                cursor_col_next = cursor_col_reg + COL_W'(1);
            end
        end
    end

    // Raster lookup and advance
    always_comb begin
        row_ok     = (32'(raster_cy_reg) < TEXT_ROWS);
        rd_row_idx = row_ok ? raster_cy_reg[ROW_IDX_W-1:0] : '0;
        rd_row_len = row_len_reg[rd_row_idx];
        cell_ok    = row_ok && (32'(raster_cx_reg) < TEXT_COLS) &&
                     (32'(raster_ix_reg) < GLYPH_W);
        show       = cell_ok && (raster_cx_reg < {1'b0, rd_row_len});
        rd_addr    = cell_ok ?
                     ADDR_W'(32'(raster_cy_reg) * TEXT_COLS + 32'(raster_cx_reg)) : '0;
        bit_idx    = BIT_W'(32'(raster_jy_reg) * GLYPH_W + 32'(raster_ix_reg));
        last_pix   = (32'(raster_x_reg) == SCREEN_WIDTH - 1) &&
                     (32'(raster_y_reg) == SCREEN_HEIGHT - 1);
        x_wrap     = (32'(raster_x_reg) + 1 >= SCREEN_WIDTH);
        y_wrap     = (32'(raster_y_reg) + 1 >= SCREEN_HEIGHT);

        raster_x_next  = raster_x_reg;
        raster_y_next  = raster_y_reg;
        raster_cx_next = raster_cx_reg;
        raster_ix_next = raster_ix_reg;
        raster_cy_next = raster_cy_reg;
        raster_jy_next = raster_jy_reg;
        if (is_pixel) begin
            if (x_wrap) begin
                raster_x_next  = '0;
                raster_cx_next = '0;
                raster_ix_next = '0;
                if (y_wrap) begin
                    raster_y_next  = '0;
                    raster_cy_next = '0;
                    raster_jy_next = '0;
                end else begin
                    raster_y_next = raster_y_reg + RY_W'(1);
                    if (32'(raster_jy_reg) == GLYPH_H - 1) begin
                        raster_jy_next = '0;
                        raster_cy_next = raster_cy_reg + CY_W'(1);
                    end else begin
                        raster_jy_next = raster_jy_reg + JY_W'(1);
                    end
                end
            end else begin
                raster_x_next = raster_x_reg + RX_W'(1);
                if (32'(raster_ix_reg) == CELL_W - 1) begin
                    raster_ix_next = '0;
                    raster_cx_next = raster_cx_reg + CX_W'(1);
                end else begin
                    raster_ix_next = raster_ix_reg + IX_W'(1);
                end
            end
        end
    end

    // Character store
    tcpr_text_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (wr_addr),
        .wr_data (s_char_code[CHAR_W-1:0]),
        .rd_en   (is_pixel),
        .rd_addr (rd_addr),
        .rd_data (rd_code)
    );

    // Font lookup and color select
    always_comb begin
        glyph    = tcpr_glyph(rd_code - SPACE7);
        glyph_on = s1_show_reg && (rd_code >= SPACE7) && glyph[s1_bit_reg];
    end

    // Configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg <= FG_RESET;
            bg_color_reg <= BG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FG_COLOR: fg_color_reg <= cfg_data;
                CFG_BG_COLOR: bg_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cursor, row lengths and raster state
    always_ff @(posedge aclk) begin
        if (!aresetn || is_clear) begin
            for (int r = 0; r < TEXT_ROWS; r++) begin
                row_len_reg[r] <= '0;
            end
        end else if (store_wr) begin
            row_len_reg[cur_row_idx] <= cursor_col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            raster_x_reg   <= '0;
            raster_y_reg   <= '0;
            raster_cx_reg  <= '0;
            raster_ix_reg  <= '0;
            raster_cy_reg  <= '0;
            raster_jy_reg  <= '0;
        end else begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            raster_x_reg   <= raster_x_next;
            raster_y_reg   <= raster_y_next;
            raster_cx_reg  <= raster_cx_next;
            raster_ix_reg  <= raster_ix_next;
            raster_cy_reg  <= raster_cy_next;
            raster_jy_reg  <= raster_jy_next;
        end
    end

    // Lookup stage: load on pixel transaction, drain into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (is_pixel) begin
            s1_valid_reg <= 1'b1;
        end else if (out_load) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_pixel) begin
            s1_show_reg <= show;
            s1_bit_reg  <= bit_idx;
            s1_last_reg <= last_pix;
        end
    end

    // Result register: hold until the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pixel_color_reg <= glyph_on ? fg_color_reg : bg_color_reg;
            m_last_reg        <= s1_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_color   = m_pixel_color_reg;
    assign m_last_of_frame = m_last_reg;

    // Checks on cursor, raster tracking and stage flow
    `TCPR_ASSERT_ALWAYS(a_raster_x_split,
        32'(raster_cx_reg) * CELL_W + 32'(raster_ix_reg) == 32'(raster_x_reg))
    `TCPR_ASSERT_ALWAYS(a_raster_y_split,
        32'(raster_cy_reg) * GLYPH_H + 32'(raster_jy_reg) == 32'(raster_y_reg))
    `TCPR_ASSERT_ALWAYS(a_cursor_col_bound, 32'(cursor_col_reg) <= TEXT_COLS)
    `TCPR_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !out_free, s1_valid_reg)
    `TCPR_ASSERT_NEXT(a_clear_home, is_clear, cursor_row_reg == '0 && cursor_col_reg == '0)

endmodule

// ===== hw/rtl/tcpr_text_store.sv =====
// Character store RAM: one write port, one registered read port.
// Depends on tcpr_pkg for the character width.
module tcpr_text_store #(
    parameter int DEPTH  = tcpr_pkg::TEXT_ROWS_DEF * tcpr_pkg::TEXT_COLS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [tcpr_pkg::CHAR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [tcpr_pkg::CHAR_W-1:0] rd_data
);
    import tcpr_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    // Write a character cell
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read a cell and hold the data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/text_console_pixel_renderer_test.sv =====
`timescale 1ns / 100ps
// Self-checking renderer bench: directed table, mixed traffic, full-speed stall, cursor lock.
// Keeps its own console, font and raster model and checks every pixel transaction against it.
// Depends on tcpr_pkg and text_console_pixel_renderer only.
module text_console_pixel_renderer_test;
    import tcpr_pkg::*;

    // Console and screen geometry
    localparam int CON_ROWS    = 24;
    localparam int CON_COLS    = 56;
    localparam int SCR_W       = 320;
    localparam int SCR_H       = 240;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 10;
    localparam int CELL_PIX_W  = GLYPH_COLS + 1;
    localparam int GLYPH_BYTES = 7;
    localparam int STORE_CELLS = CON_ROWS * CON_COLS;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam color_t INK_AT_RESET   = 16'hFFFF;
    localparam color_t PAPER_AT_RESET = 16'h001F;

    typedef struct packed {
        color_t color;
        logic   last;
    } pixel_rec_t;

    typedef struct packed {
        logic [1:0] kind;
        code_t      code;
        logic       typed;
        color_t     color;
        logic       last;
    } stim_row_t;

    // Font: 7 bytes per glyph for codes 0x20..0x7F, LSB first in raster order
    logic [7:0] font_rom [0:96*GLYPH_BYTES-1] = '{
        'h00,'h00,'h00,'h00,'h00,'h00,'h00, 'h80,'h10,'h42,'h08,'h20,'h00,'h00,
        'h4A,'h29,'h00,'h00,'h00,'h00,'h00, 'h00,'hA8,'hAF,'hD4,'h57,'h00,'h00,
        'h80,'hF8,'hE2,'hE8,'h23,'h00,'h00, 'h60,'h4E,'h44,'h44,'hCE,'h00,'h00,
        'hC0,'hA4,'h64,'h6A,'hB2,'h00,'h00, 'h84,'h10,'h00,'h00,'h00,'h00,'h00,
        'h88,'h08,'h21,'h84,'h20,'h08,'h00, 'h82,'h20,'h84,'h10,'h22,'h02,'h00,
        'h00,'h90,'hEA,'h2A,'h01,'h00,'h00, 'h00,'h10,'hF2,'h09,'h01,'h00,'h00,
        'h00,'h00,'h00,'h00,'h20,'h02,'h00, 'h00,'h00,'hF0,'h01,'h00,'h00,'h00,
        'h00,'h00,'h00,'h00,'h20,'h00,'h00, 'h10,'h22,'h44,'h88,'h10,'h01,'h00,
        'hC0,'hC5,'h58,'h63,'h74,'h00,'h00, 'h80,'h18,'h42,'h08,'h71,'h00,'h00,
        'hC0,'h45,'hC8,'h44,'hF8,'h00,'h00, 'hC0,'h45,'hC8,'h60,'h74,'h00,'h00,
        'h00,'h31,'h95,'h3E,'h42,'h00,'h00, 'hE0,'h87,'hF0,'h60,'h74,'h00,'h00,
        'h80,'h89,'hF0,'h62,'h74,'h00,'h00, 'hE0,'h43,'h84,'h08,'h11,'h00,'h00,
        'hC0,'hC5,'hE8,'h62,'h74,'h00,'h00, 'hC0,'hC5,'hE8,'h21,'h32,'h00,'h00,
        'h00,'h00,'h02,'h00,'h01,'h00,'h00, 'h00,'h00,'h02,'h00,'h11,'h00,'h00,
        'h00,'h40,'h36,'h18,'h04,'h00,'h00, 'h00,'h80,'h0F,'h3E,'h00,'h00,'h00,
        'h00,'h04,'h83,'h4D,'h00,'h00,'h00, 'hC0,'h45,'h88,'h08,'h20,'h00,'h00,
        'hC0,'hC5,'h5A,'h7B,'hF0,'h00,'h00, 'h80,'h10,'hA5,'h5C,'h8C,'h00,'h00,
        'hE0,'hC5,'hF8,'h62,'h7C,'h00,'h00, 'hC0,'hC5,'h10,'h42,'h74,'h00,'h00,
        'hE0,'hA4,'h18,'h63,'h3A,'h00,'h00, 'hE0,'h87,'hF0,'h42,'hF8,'h00,'h00,
        'hE0,'h87,'hF0,'h42,'h08,'h00,'h00, 'hC0,'hC5,'h90,'h63,'hF4,'h00,'h00,
        'h20,'hC6,'hF8,'h63,'h8C,'h00,'h00, 'hC0,'h11,'h42,'h08,'h71,'h00,'h00,
        'h80,'h43,'h08,'h21,'h7C,'h00,'h00, 'h20,'hA6,'h32,'h4A,'h8A,'h00,'h00,
        'h20,'h84,'h10,'h42,'hF8,'h00,'h00, 'h20,'hC6,'hBD,'h6B,'h8D,'h00,'h00,
        'h60,'hCE,'h5A,'h6B,'hCE,'h00,'h00, 'hC0,'hC5,'h18,'h63,'h74,'h00,'h00,
        'hE0,'hC5,'hF8,'h42,'h08,'h00,'h00, 'hC0,'hC5,'h18,'h63,'hF6,'h00,'h00,
        'hE0,'hC5,'hF8,'h62,'h8C,'h00,'h00, 'hC0,'hC5,'hE0,'h60,'h74,'h00,'h00,
        'hE0,'h13,'h42,'h08,'h21,'h00,'h00, 'h20,'hC6,'h18,'h63,'h74,'h00,'h00,
        'h20,'hC6,'hA8,'h14,'h21,'h00,'h00, 'h20,'hD6,'h5A,'h95,'h52,'h00,'h00,
        'h20,'h46,'h45,'h54,'h8C,'h00,'h00, 'h20,'hC6,'hE8,'h08,'h21,'h00,'h00,
        'hE0,'h43,'h44,'h44,'hF8,'h00,'h00, 'h4E,'h08,'h21,'h84,'h10,'h0E,'h00,
        'h21,'h08,'h41,'h08,'h42,'h10,'h00, 'h0E,'h21,'h84,'h10,'h42,'h0E,'h00,
        'h80,'hA8,'h08,'h00,'h00,'h00,'h00, 'h00,'h00,'h00,'h00,'h00,'h1F,'h00,
        'h80,'h20,'h00,'h00,'h00,'h00,'h00, 'h00,'h00,'h07,'h7D,'hF4,'h00,'h00,
        'h21,'h84,'h17,'h63,'h7C,'h00,'h00, 'h00,'h00,'h1F,'h42,'hF0,'h00,'h00,
        'h10,'h42,'h1F,'h63,'hF4,'h00,'h00, 'h00,'h00,'h17,'h7F,'hF0,'h00,'h00,
        'h5C,'h88,'h27,'h84,'h10,'h00,'h00, 'h00,'h00,'h17,'h63,'hF4,'hD0,'h01,
        'h21,'h84,'h17,'h63,'h8C,'h00,'h00, 'h80,'h00,'h43,'h08,'h21,'h00,'h00,
        'h00,'h01,'h86,'h10,'h42,'hE8,'h00, 'h42,'h08,'hA9,'h8C,'h92,'h00,'h00,
        'h86,'h10,'h42,'h08,'h21,'h00,'h00, 'h00,'h80,'h55,'h6B,'hAD,'h00,'h00,
        'h00,'h80,'h17,'h63,'h8C,'h00,'h00, 'h00,'h00,'h17,'h63,'h74,'h00,'h00,
        'h00,'h80,'h17,'h63,'h7C,'h21,'h00, 'h00,'h00,'h1F,'h63,'hF4,'h10,'h02,
        'h00,'h80,'h36,'h43,'h08,'h00,'h00, 'h00,'h00,'h1F,'h1C,'h7C,'h00,'h00,
        'h40,'h08,'h27,'h84,'hE0,'h00,'h00, 'h00,'h80,'h18,'h63,'hF4,'h00,'h00,
        'h00,'h80,'h18,'h95,'h22,'h00,'h00, 'h00,'h80,'h58,'hAB,'h52,'h00,'h00,
        'h00,'h80,'hA8,'h88,'h8A,'h00,'h00, 'h00,'h80,'h18,'h63,'hF4,'hD0,'h01,
        'h00,'h80,'h8F,'h88,'hF8,'h00,'h00, 'h88,'h10,'h22,'h08,'h21,'h08,'h00,
        'h84,'h10,'h42,'h08,'h21,'h04,'h00, 'h82,'h10,'h82,'h08,'h21,'h02,'h00,
        'h00,'h00,'h60,'h1B,'h00,'h00,'h00, 'h00,'h00,'h00,'h00,'h00,'h00,'h00
    };

    // Directed stimulus; typed rows carry a result that is obvious from the reset state
    localparam int DIRECTED_COUNT = 24;
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{KIND_PIXEL,  8'h00, 1'b1, 16'h001F, 1'b0},
        '{KIND_UNUSED, 8'hFF, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'hFF, 1'b1, 16'h001F, 1'b0},
        '{KIND_CHAR,   8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h1F, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h80, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'hFF, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h7F, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h20, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h0A, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h7C, 1'b0, 16'h0000, 1'b0},
        '{KIND_CLEAR,  8'h55, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h5B, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h7C, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h0A, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_PIXEL,  8'h00, 1'b0, 16'h0000, 1'b0},
        '{KIND_CHAR,   8'h41, 1'b0, 16'h0000, 1'b0}
    };

    // Block ports
    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_kind = KIND_CLEAR;
    code_t                s_char_code = 8'h00;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    color_t               m_pixel_color;
    logic                 m_last_of_frame;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FG_COLOR;
    color_t               cfg_data = 16'h0000;

    // Console model
    logic [6:0]   cell_codes [0:STORE_CELLS-1];
    logic [4:0]   cursor_row = '0;
    logic [5:0]   cursor_col = '0;
    logic [8:0]   raster_x = '0;
    logic [7:0]   raster_y = '0;
    color_t       ink_color = INK_AT_RESET;
    color_t       paper_color = PAPER_AT_RESET;
    pixel_rec_t   pending_pixels [$];

    // Traffic shaping and bookkeeping
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_request = 1'b0;
    int  hold_left = 0;
    int  error_count = 0;
    int  pixels_checked = 0;
    int  frames_done = 0;
    int  chars_stored = 0;
    int  clears_sent = 0;

    text_console_pixel_renderer #(
        .TEXT_ROWS    (CON_ROWS),
        .TEXT_COLS    (CON_COLS),
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_color  (m_pixel_color),
        .m_last_of_frame(m_last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Fill the store with spaces and home the cursor; the raster is kept
    function automatic void blank_console();
        for (int i = 0; i < STORE_CELLS; i++) begin
            cell_codes[i] = SPACE_CODE[6:0];
        end
        cursor_row = '0;
        cursor_col = '0;
    endfunction

    // Apply one character byte at the cursor; a cursor off the console locks it until a clear
    function automatic void type_char(input code_t code);
        if (cursor_row < CON_ROWS && cursor_col < CON_COLS) begin
            if (code == NEWLINE_CODE) begin
                cursor_col = '0;
                cursor_row = cursor_row + 5'd1;
            end else if (code >= SPACE_CODE && code <= LAST_PRINT) begin
                cell_codes[int'(cursor_row) * CON_COLS + int'(cursor_col)] = code[6:0];
                cursor_col = cursor_col + 6'd1;
                chars_stored++;
            end
        end
    endfunction

    // Color the current raster position, then step the raster
    function automatic pixel_rec_t render_next_pixel();
        pixel_rec_t pix;
        int         cell_x, cell_y, gx, gy, glyph_bit, code7;
        logic       lit;
        if (raster_x >= SCR_W || raster_y >= SCR_H) begin
            raster_x = '0;
            raster_y = '0;
        end
        cell_x = raster_x / CELL_PIX_W;
        cell_y = raster_y / GLYPH_ROWS;
        gx = raster_x % CELL_PIX_W;
        gy = raster_y % GLYPH_ROWS;
        lit = 1'b0;
        if (cell_y < CON_ROWS && cell_x < CON_COLS && gx < GLYPH_COLS) begin
            code7 = cell_codes[cell_y * CON_COLS + cell_x];
            if (code7 >= int'(SPACE_CODE)) begin
                glyph_bit = gx + gy * GLYPH_COLS;
                lit = font_rom[(code7 - int'(SPACE_CODE)) * GLYPH_BYTES
                               + glyph_bit / 8][glyph_bit % 8];
            end
        end
        pix.color = lit ? ink_color : paper_color;
        pix.last = (raster_x == SCR_W - 1) && (raster_y == SCR_H - 1);
        if (pix.last) begin
            frames_done++;
        end
        if (raster_x + 1 >= SCR_W) begin
            raster_x = '0;
            raster_y = (raster_y + 1 >= SCR_H) ? 8'd0 : raster_y + 8'd1;
        end else begin
            raster_x = raster_x + 9'd1;
        end
        return pix;
    endfunction

    // Offer one transaction on the input channel and update the model once it is taken.
    // Entered and left at a falling edge; valid is left high for the caller to reuse or drop.
    task automatic send_item(input logic [1:0] kind, input code_t code,
                             input logic typed, input pixel_rec_t typed_pixel);
        pixel_rec_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_char_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (kind)
            KIND_CLEAR: begin
                blank_console();
                clears_sent++;
            end
            KIND_CHAR: type_char(code);
            KIND_PIXEL: begin
                predicted = render_next_pixel();
                pending_pixels.push_back(typed ? typed_pixel : predicted);
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Drop valid and wait for every pixel in flight, then wait further for writes to land
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write both color registers back to back; call only while the block is idle
    task automatic set_colors(input color_t ink, input color_t paper);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FG_COLOR;
        cfg_data <= ink;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ink_color = ink;
        @(negedge aclk);
        cfg_index <= CFG_BG_COLOR;
        cfg_data <= paper;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        paper_color = paper;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        repeat (2) @(negedge aclk);
    endtask

    // Mostly typed lines and pixel bursts, with clears and some noise of any kind and byte
    task automatic run_mixed_traffic(input int target);
        int         sent, len, pick;
        logic [1:0] noise_kind;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // lines past the last column lock the cursor until the next clear
                len = $urandom_range(0, 62);
                repeat (len) begin
                    send_item(KIND_CHAR, code_t'($urandom_range(32, 127)), 1'b0, '0);
                end
                if ($urandom_range(0, 3) != 0) begin
                    send_item(KIND_CHAR, NEWLINE_CODE, 1'b0, '0);
                    sent++;
                end
                sent += len;
            end else if (pick < 75) begin
                len = $urandom_range(1, 40);
                repeat (len) begin
                    send_item(KIND_PIXEL, code_t'($urandom), 1'b0, '0);
                end
                sent += len;
            end else if (pick < 80) begin
                send_item(KIND_CLEAR, code_t'($urandom), 1'b0, '0);
                sent++;
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    noise_kind = ($urandom_range(0, 9) == 0) ? KIND_CLEAR
                                                             : 2'($urandom_range(1, 3));
                    send_item(noise_kind, code_t'($urandom), 1'b0, '0);
                end
                sent += len;
            end
        end
    endtask

    // Result receiver: random back-pressure, or a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 200;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each pixel transaction against the oldest prediction
    always @(posedge aclk) begin
        pixel_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                $error("pixel transaction with none expected: pixel_color %h last_of_frame %b",
                       m_pixel_color, m_last_of_frame);
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_pixel_color !== want.color) begin
                    error_count++;
                    $error("pixel_color: expected %h, actual %h", want.color, m_pixel_color);
                end
                if (m_last_of_frame !== want.last) begin
                    error_count++;
                    $error("last_of_frame: expected %b, actual %b", want.last,
                           m_last_of_frame);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int   pick;
        color_t ink;
        blank_console();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table at reset colors, sender lightly idle, receiver mostly stalled
        send_idle_pct = 29;
        recv_idle_pct = 88;
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].kind, directed_rows[i].code, directed_rows[i].typed,
                      {directed_rows[i].color, directed_rows[i].last});
        end
        drain();

        // Extreme colors, same idling
        set_colors(16'h0000, 16'hFFFF);
        run_mixed_traffic(240);
        drain();

        // Random colors, idling swapped
        send_idle_pct = 88;
        recv_idle_pct = 29;
        ink = color_t'($urandom);
        set_colors(ink, ~ink);
        run_mixed_traffic(240);
        drain();

        // Full speed: type a few short lines, then pixels against a stalled receiver
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_colors(16'hFFFF, 16'h0000);
        send_item(KIND_CLEAR, 8'h00, 1'b0, '0);
        for (int row = 0; row < 2; row++) begin
            repeat (8) begin
                send_item(KIND_CHAR, code_t'($urandom_range(32, 127)), 1'b0, '0);
            end
            send_item(KIND_CHAR, NEWLINE_CODE, 1'b0, '0);
        end
        // stall the receiver while pixels keep coming so the block backs up
        hold_request = 1'b1;
        repeat (40) begin
            pick = $urandom_range(0, 99);
            if (pick < 95) begin
                send_item(KIND_PIXEL, code_t'($urandom), 1'b0, '0);
            end else begin
                // writes into the store while the raster is being scanned
                send_item(KIND_CHAR, code_t'($urandom_range(32, 127)), 1'b0, '0);
            end
        end

        // Push the cursor below the last row; later characters must not land anywhere
        send_item(KIND_CLEAR, 8'hFF, 1'b0, '0);
        repeat (CON_ROWS) begin
            send_item(KIND_CHAR, NEWLINE_CODE, 1'b0, '0);
        end
        repeat (8) begin
            send_item(KIND_CHAR, 8'h23, 1'b0, '0);
        end
        send_item(KIND_CHAR, NEWLINE_CODE, 1'b0, '0);
        repeat (20) begin
            send_item(KIND_PIXEL, code_t'($urandom), 1'b0, '0);
        end
        drain();
        repeat (10) @(posedge aclk);

        $display("Checked %0d pixel transactions across %0d frame ends", pixels_checked,
                 frames_done);
        $display("Console saw %0d stored characters and %0d clears under four color settings",
                 chars_stored, clears_sent);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tcpr_pkg.sv
hw/rtl/tcpr_text_store.sv
hw/rtl/text_console_pixel_renderer.sv
sim/text_console_pixel_renderer_test.sv
